// File: src/hdlc_like_iframe_framer_core_assert.svh
// Assertion macros for the checker file of the framer.
// Expects clk and rst_n in the scope of use.
`ifndef HDLC_LIKE_IFRAME_FRAMER_CORE_ASSERT_SVH
`define HDLC_LIKE_IFRAME_FRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define HIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// next-cycle implication
`define HIF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// File: src/hif_pkg.sv
// Types, constants and register codes for the framer.
// No dependencies.
package hif_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_FLAG      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLAG_SUB  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ESC_SUB   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CTRL_ZERO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CTRL_ONE  = 3'd6;

  localparam logic [7:0] RST_FLAG      = 8'd126;
  localparam logic [7:0] RST_ESCAPE    = 8'd125;
  localparam logic [7:0] RST_FLAG_SUB  = 8'd94;
  localparam logic [7:0] RST_ESC_SUB   = 8'd93;
  localparam logic [7:0] RST_ADDRESS   = 8'd3;
  localparam logic [7:0] RST_CTRL_ZERO = 8'd0;
  localparam logic [7:0] RST_CTRL_ONE  = 8'd64;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
    logic [7:0] address_byte;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_FLAG,
    KIND_ESC
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] chk;
    logic       first;
    logic       last;
    logic       seq;
    kind_t      dkind;
    kind_t      ckind;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_HCHK,
    ST_DATA,
    ST_DSUB,
    ST_CHK,
    ST_CSUB,
    ST_CLOSE
  } step_t;

  function automatic kind_t classify(logic [7:0] b, cfg_t c);
    kind_t k;
    if (b == c.flag_byte) k = KIND_FLAG;
    else if (b == c.escape_byte) k = KIND_ESC;
    else k = KIND_PLAIN;
    return k;
  endfunction

endpackage

// File: src/hif_if.sv
// Channel interfaces of the framer: payload input, byte output, register writes.
// No dependencies.
interface hif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       seq_bit;
  modport source (output valid, data_byte, last_byte, seq_bit, input ready);
  modport sink   (input valid, data_byte, last_byte, seq_bit, output ready);
endinterface

interface hif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       last_of_run;
  modport source (output valid, out_byte, frame_end, last_of_run, input ready);
  modport sink   (input valid, out_byte, frame_end, last_of_run, output ready);
endinterface

interface hif_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/hif_front.sv
// Front end: accepts payload items, tracks frame state and running XOR,
// classifies bytes for stuffing. Depends on hif_pkg.
module hif_front (
  input  logic          clk,
  input  logic          rst_n,
  input  hif_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic          in_seq_bit,
  output logic          push,
  output hif_pkg::job_t push_job,
  input  logic          q_full
);
  import hif_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] chk;
  logic       first;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign first    = !in_frame_r;
  assign chk      = first ? in_data_byte : (xor_r ^ in_data_byte);

  always_comb begin
    push_job.data  = in_data_byte;
    push_job.chk   = chk;
    push_job.first = first;
    push_job.last  = in_last_byte;
    push_job.seq   = in_seq_bit;
    push_job.dkind = classify(in_data_byte, cfg);
    push_job.ckind = classify(chk, cfg);
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    xor_nxt      = xor_r;
    if (push) begin
      in_frame_nxt = !in_last_byte;
      xor_nxt      = in_last_byte ? 8'd0 : chk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      xor_r      <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      xor_r      <= xor_nxt;
    end
  end
endmodule

// File: src/hif_queue.sv
// Two-entry job queue between front and back end.
// Depends on hif_pkg.
module hif_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hif_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output hif_pkg::job_t head_job
);
  import hif_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end
endmodule

// File: src/hif_back.sv
// Back end: steps through the bytes of each job, one per cycle while the output
// is not stalled, into a registered output stage. Depends on hif_pkg.
module hif_back (
  input  logic          clk,
  input  logic          rst_n,
  input  hif_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  hif_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_frame_end,
  output logic          out_last_of_run
);
  import hif_pkg::*;

  step_t      step_r, step_nxt;
  step_t      cur, nxt;
  logic       done;
  logic       load;
  logic [7:0] ctrl;
  logic [7:0] byte_c;
  logic       fend_c;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       fend_r, lor_r;

  assign load = head_valid && (!valid_r || out_ready);
  assign pop  = load && done;
  assign ctrl = head_job.seq ? cfg.control_seq_one : cfg.control_seq_zero;

  always_comb begin
    if (step_r == ST_IDLE) cur = head_job.first ? ST_FLAG : ST_DATA;
    else cur = step_r;
  end

  // next step
  always_comb begin
    nxt  = ST_IDLE;
    done = 1'b0;
    unique case (cur)
      ST_FLAG: nxt = ST_ADDR;
      ST_ADDR: nxt = ST_CTRL;
      ST_CTRL: nxt = ST_HCHK;
      ST_HCHK: nxt = ST_DATA;
      ST_DATA: begin
        if (head_job.dkind != KIND_PLAIN) nxt = ST_DSUB;
        else if (head_job.last) nxt = ST_CHK;
        else done = 1'b1;
      end
      ST_DSUB: begin
        if (head_job.last) nxt = ST_CHK;
        else done = 1'b1;
      end
      ST_CHK:  nxt = (head_job.ckind != KIND_PLAIN) ? ST_CSUB : ST_CLOSE;
      ST_CSUB: nxt = ST_CLOSE;
      ST_CLOSE: done = 1'b1;
      default: done = 1'b1;
    endcase
  end

  // byte for the current step
  always_comb begin
    byte_c = cfg.flag_byte;
    fend_c = 1'b0;
    unique case (cur)
      ST_FLAG: byte_c = cfg.flag_byte;
      ST_ADDR: byte_c = cfg.address_byte;
      ST_CTRL: byte_c = ctrl;
      ST_HCHK: byte_c = cfg.address_byte ^ ctrl;
      ST_DATA: byte_c = (head_job.dkind == KIND_PLAIN) ? head_job.data : cfg.escape_byte;
      ST_DSUB: byte_c = (head_job.dkind == KIND_FLAG) ? cfg.flag_substitute
                                                      : cfg.escape_substitute;
      ST_CHK:  byte_c = (head_job.ckind == KIND_PLAIN) ? head_job.chk : cfg.escape_byte;
      ST_CSUB: byte_c = (head_job.ckind == KIND_FLAG) ? cfg.flag_substitute
                                                      : cfg.escape_substitute;
      ST_CLOSE: begin
        byte_c = cfg.flag_byte;
        fend_c = 1'b1;
      end
      default: byte_c = cfg.flag_byte;
    endcase
  end

  assign step_nxt = load ? (done ? ST_IDLE : nxt) : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_c;
      fend_r <= fend_c;
      lor_r  <= done;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_frame_end   = fend_r;
  assign out_last_of_run = lor_r;
endmodule

// File: src/hdlc_like_iframe_framer_core.sv
// Top level of the information frame framer: register file, front end,
// job queue and back end. Depends on hif_pkg, hif_if, hif_front, hif_queue, hif_back.
//
// Usage:
//   in_ch  : payload items (data_byte, last_byte, seq_bit), valid/ready.
//   out_ch : line bytes (out_byte, frame_end, last_of_run), valid/ready.
//   cfg_ch : register writes (index, data); always ready, takes effect next cycle.
// An item opening a frame yields flag, address, control and header check, then
// the stuffed payload byte; an item marked last adds the stuffed XOR check and
// the closing flag (frame_end). last_of_run marks the final byte of each item.
// An accepted item passes through the job queue, then the registered output stage.
// Throughput: one output byte per cycle while out_ch is ready and items wait; an
// item yields 1 to 9 output bytes, a plain mid-frame byte 1 and a stuffed one 2. The
// output port rate sets the pace, and a two-entry job queue lets input run ahead.
// Reset: no frame open, running XOR zero, registers at their defaults, queue
// and output stage empty.
// Receiver stall: the output byte holds; the queue fills and in_ch.ready drops
// once two items are waiting.
module hdlc_like_iframe_framer_core (
  input logic      clk,
  input logic      rst_n,
  hif_in_if.sink   in_ch,
  hif_out_if.source out_ch,
  hif_cfg_if.sink  cfg_ch
);
  import hif_pkg::*;

  cfg_t cfg_r;
  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte         <= RST_FLAG;
      cfg_r.escape_byte       <= RST_ESCAPE;
      cfg_r.flag_substitute   <= RST_FLAG_SUB;
      cfg_r.escape_substitute <= RST_ESC_SUB;
      cfg_r.address_byte      <= RST_ADDRESS;
      cfg_r.control_seq_zero  <= RST_CTRL_ZERO;
      cfg_r.control_seq_one   <= RST_CTRL_ONE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FLAG:      cfg_r.flag_byte         <= cfg_ch.data;
        CFG_ESCAPE:    cfg_r.escape_byte       <= cfg_ch.data;
        CFG_FLAG_SUB:  cfg_r.flag_substitute   <= cfg_ch.data;
        CFG_ESC_SUB:   cfg_r.escape_substitute <= cfg_ch.data;
        CFG_ADDRESS:   cfg_r.address_byte      <= cfg_ch.data;
        CFG_CTRL_ZERO: cfg_r.control_seq_zero  <= cfg_ch.data;
        CFG_CTRL_ONE:  cfg_r.control_seq_one   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  hif_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_last_byte (in_ch.last_byte),
    .in_seq_bit   (in_ch.seq_bit),
    .push         (push),
    .push_job     (push_job),
    .q_full       (q_full)
  );

  hif_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  hif_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .out_frame_end   (out_ch.frame_end),
    .out_last_of_run (out_ch.last_of_run)
  );
endmodule

// File: src/hif_checker.sv
// Port-level checks for the framer, bound to the top level.
// Depends on hdlc_like_iframe_framer_core_assert.svh.
`include "hdlc_like_iframe_framer_core_assert.svh"

module hif_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_frame_end,
  input logic       out_last_of_run,
  input logic       in_valid,
  input logic       in_ready,
  input logic       cfg_ready
);
  logic [9:0] out_word;

  assign out_word = {out_byte, out_frame_end, out_last_of_run};

  `HIF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `HIF_ASSERT_IMP(a_end_is_last, out_valid && out_frame_end, out_last_of_run)
  `HIF_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready)
  // item goes through the queue first, then the registered output stage
  `HIF_ASSERT_NXT(a_accept_output, in_valid && in_ready && !out_valid, ##1 out_valid)
endmodule

bind hdlc_like_iframe_framer_core hif_checker u_hif_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_byte        (out_ch.out_byte),
  .out_frame_end   (out_ch.frame_end),
  .out_last_of_run (out_ch.last_of_run),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .cfg_ready       (cfg_ch.ready)
);
